>>> src/utf8_byte_stream_decoder_defines.svh
// Assertion macros for the UTF-8 byte stream decoder.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define UTF8D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the next edge.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define UTF8D_ASSERT(lbl, prop, msg)
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/utf8d_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies.
package utf8d_pkg;

	localparam int CP_W    = 21;
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 32;

	localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

	localparam logic [CP_W-1:0] ERR_CHAR = 21'h00002E;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = '1;

	// Result queue depth; two free slots are needed to take a byte.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [CP_W-1:0]    code_point;
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] bytes_taken;
		logic               at_limit;
		logic               chunk_end_echo;
		logic               last;
	} result_t;

	// Results produced by one byte: count (0..2) and the two slots.
	typedef struct packed {
		logic [1:0] n;
		result_t    item0;
		result_t    item1;
	} push_t;

endpackage

>>> src/utf8d_decode.sv
// Decode step: holds the sequence state and consumed count, turns one
// registered byte into zero to two results. Depends on utf8d_pkg.
module utf8d_decode
	import utf8d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         byte_value,
	input  logic               start_of_string,
	input  logic               chunk_end,
	input  logic [COUNT_W-1:0] length_limit,
	output push_t              push
);

	logic [1:0]         pending_q;
	logic [CP_W-1:0]    acc_q;
	logic [COUNT_W-1:0] consumed_q;

	logic [1:0]         pend_eff, pend_n;
	logic [CP_W-1:0]    acc_eff, acc_n, acc_shift;
	logic [COUNT_W-1:0] cons_eff, cons_inc, cons_n;
	logic               refused, atl;
	result_t            err_item, chr_item, ref_item;

	// Start of string clears everything before the limit check.
	assign pend_eff  = start_of_string ? 2'd0 : pending_q;
	assign acc_eff   = start_of_string ? '0 : acc_q;
	assign cons_eff  = start_of_string ? '0 : consumed_q;
	assign refused   = (cons_eff >= length_limit);
	assign cons_inc  = cons_eff + 1'b1;
	assign cons_n    = refused ? cons_eff : cons_inc;
	assign atl       = (cons_n == length_limit);
	assign acc_shift = {acc_eff[CP_W-7:0], byte_value[5:0]};

	always_comb begin
		err_item = '{code_point: ERR_CHAR, kind: KIND_ERROR, bytes_taken: cons_n,
			at_limit: atl, chunk_end_echo: chunk_end, last: 1'b0};
		chr_item = '{code_point: {{(CP_W-8){1'b0}}, byte_value}, kind: KIND_CHAR,
			bytes_taken: cons_n, at_limit: atl, chunk_end_echo: chunk_end, last: 1'b0};
		ref_item = '{code_point: '0, kind: KIND_REFUSED, bytes_taken: cons_n,
			at_limit: atl, chunk_end_echo: chunk_end, last: 1'b1};

		push   = '0;
		pend_n = pend_eff;
		acc_n  = acc_eff;

		if (refused) begin
			push.n     = 2'd1;
			push.item0 = ref_item;
		end else if (byte_value <= 8'h7F) begin
			pend_n = 2'd0;
			if (pend_eff != 2'd0) begin
				push.n     = 2'd2;
				push.item0 = err_item;
				push.item1 = chr_item;
			end else begin
				push.n     = 2'd1;
				push.item0 = chr_item;
			end
		end else if (byte_value <= 8'hBF) begin
			if (pend_eff != 2'd0) begin
				acc_n  = acc_shift;
				pend_n = pend_eff - 2'd1;
				if (pend_eff == 2'd1) begin
					push.n                = 2'd1;
					push.item0            = chr_item;
					push.item0.code_point = acc_shift;
				end
			end else begin
				push.n     = 2'd1;
				push.item0 = err_item;
			end
		end else if (byte_value <= 8'hDF) begin
			pend_n = 2'd1;
			acc_n  = {{(CP_W-5){1'b0}}, byte_value[4:0]};
		end else if (byte_value <= 8'hEF) begin
			pend_n = 2'd2;
			acc_n  = {{(CP_W-4){1'b0}}, byte_value[3:0]};
		end else if (byte_value <= 8'hF7) begin
			pend_n = 2'd3;
			acc_n  = {{(CP_W-3){1'b0}}, byte_value[2:0]};
		end else begin
			pend_n     = 2'd0;
			push.n     = 2'd1;
			push.item0 = err_item;
		end

		if (push.n == 2'd1)
			push.item0.last = 1'b1;
		if (push.n == 2'd2)
			push.item1.last = 1'b1;
		if (!step)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 2'd0;
			acc_q      <= '0;
			consumed_q <= '0;
		end else if (step) begin
			pending_q  <= pend_n;
			acc_q      <= acc_n;
			consumed_q <= cons_n;
		end
	end

endmodule

>>> src/utf8d_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on utf8d_pkg.
module utf8d_out_fifo
	import utf8d_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	result_t              mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_p1;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	assign room      = (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_ptr_q] <= push.item0;
		if (push.n == 2'd2)
			mem_q[wr_ptr_p1] <= push.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push.n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OUT_CNT_W'(push.n) - OUT_CNT_W'(pop);
		end
	end

endmodule

>>> src/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder: input register, limit register,
// decode step and result queue. Depends on utf8d_pkg, utf8d_decode,
// utf8d_out_fifo and utf8_byte_stream_decoder_defines.svh.
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+----------------------------------
//  in       | in_valid / in_ready                | byte_value, start_of_string,
//           |                                    | chunk_end
//  out      | out_valid / out_ready              | code_point, kind, bytes_taken,
//           |                                    | at_limit, chunk_end_echo, last
//  config   | length_limit_we (no wait)          | length_limit_wdata
//
// One byte per cycle while the queue has room; an ASCII byte that drops a pending
// sequence gives two results, which leave the single result port one after the other.
// A byte passes through the input register, then the result queue, before its
// first result is offered.
// Reset clears sequence state, consumed count and queue; limit goes to all ones.
// A stalled result port backs up into in_ready once the queue has < 2 free slots.
`include "utf8_byte_stream_decoder_defines.svh"

module utf8_byte_stream_decoder
	import utf8d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         byte_value,
	input  logic               start_of_string,
	input  logic               chunk_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CP_W-1:0]    code_point,
	output logic [KIND_W-1:0]  kind,
	output logic [COUNT_W-1:0] bytes_taken,
	output logic               at_limit,
	output logic               chunk_end_echo,
	output logic               last,
	input  logic               length_limit_we,
	input  logic [COUNT_W-1:0] length_limit_wdata
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               sos_s1;
	logic               chunk_s1;
	logic [COUNT_W-1:0] length_limit_q;
	logic               room, step;
	push_t              push;
	result_t            head;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= byte_value;
			sos_s1   <= start_of_string;
			chunk_s1 <= chunk_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_limit_q <= LIMIT_RESET;
		end else if (length_limit_we) begin
			length_limit_q <= length_limit_wdata;
		end
	end

	utf8d_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.byte_value      (byte_s1),
		.start_of_string (sos_s1),
		.chunk_end       (chunk_s1),
		.length_limit    (length_limit_q),
		.push            (push)
	);

	utf8d_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign code_point     = head.code_point;
	assign kind           = head.kind;
	assign bytes_taken    = head.bytes_taken;
	assign at_limit       = head.at_limit;
	assign chunk_end_echo = head.chunk_end_echo;
	assign last           = head.last;

	// A refused byte always yields a single zero result.
	`UTF8D_ASSERT(a_refused_item, !(out_valid && kind == KIND_REFUSED) || (code_point == '0 && last), "refused result must carry code point 0 and last")
	// Error substitutes always carry the dot character.
	`UTF8D_ASSERT(a_error_char, !(out_valid && kind == KIND_ERROR) || code_point == ERR_CHAR, "error result must carry 0x2E")
	// The second result of a byte is queued together with the first.
	`UTF8D_ASSERT_NEXT(a_pair_queued, out_valid && out_ready && !last, out_valid, "result without last not followed by its partner")
	// Input register only blocks while it holds a byte.
	`UTF8D_ASSERT(a_stall_holds, in_ready || valid_s1, "input stalled with empty input register")

endmodule
